// ===== rtl/cru_pkg.sv =====
// ----------------------------------------------------------------------------
// cru_pkg: shared types, codes and helpers of the Cholesky rank-one updater
// Request layout, function and status codes, Q8.24 magnitude and saturation.
// ----------------------------------------------------------------------------
package cru_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int DATA_W      = 32;
    localparam int DIM_W       = 4;
    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] FUNC_WR  = 2'd0;
    localparam logic [1:0] FUNC_RD  = 2'd1;
    localparam logic [1:0] FUNC_LD  = 2'd2;
    localparam logic [1:0] FUNC_NOP = 2'd3;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NEGRAD = 2'd1;
    localparam logic [1:0] STAT_ZPIV   = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
        logic               start;
        logic               down;
    } t_req;

    function automatic logic [31:0] f_mag(input logic signed [31:0] v);
        f_mag = v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [47:0] v);
        if (v > 48'sd2147483647) begin
            f_sat32 = 32'sh7fffffff;
        end else if (v < -48'sd2147483648) begin
            f_sat32 = 32'sh80000000;
        end else begin
            f_sat32 = v[31:0];
        end
    endfunction

endpackage

// ===== rtl/cru_ram.sv =====
// ----------------------------------------------------------------------------
// cru_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cru_div.sv =====
// ----------------------------------------------------------------------------
// cru_div: radix-2 Q8.24 divider
// Computes sat32(num * 2^24 / den), truncated toward zero, one bit a cycle.
// ----------------------------------------------------------------------------
module cru_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [39:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);

    localparam int STEPS = 64;
    localparam int CNT_W = $clog2(STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_rem;
    logic [63:0]      r_q;
    logic [31:0]      r_dmag;
    logic             r_neg;

    logic [39:0] w_nmag;
    logic [32:0] w_rem_sh;
    logic [32:0] w_diff;
    logic        w_ge;

    assign w_nmag   = i_num[39] ? 40'(-i_num) : 40'(i_num);
    assign w_rem_sh = {r_rem, r_q[63]};
    assign w_ge     = w_rem_sh >= {1'b0, r_dmag};
    assign w_diff   = w_rem_sh - {1'b0, r_dmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= {w_nmag, 24'd0};
            r_rem  <= '0;
            r_dmag <= cru_pkg::f_mag(i_den);
            r_neg  <= i_num[39] ^ i_den[31];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[31:0] : w_rem_sh[31:0];
            r_q   <= {r_q[62:0], w_ge};
        end
    end

    // saturate the magnitude quotient back into signed 32 bits
    always_comb begin
        if (r_neg) begin
            o_quot = (r_q > 64'h8000_0000) ? 32'sh80000000 : $signed(32'(-r_q[31:0]));
        end else begin
            o_quot = (r_q > 64'h7fff_ffff) ? 32'sh7fffffff : $signed(r_q[31:0]);
        end
    end

    assign o_done = r_done;

endmodule

// ===== rtl/cru_sqrt.sv =====
// ----------------------------------------------------------------------------
// cru_sqrt: digit-by-digit integer square root
// Floor square root of a 64-bit radicand, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module cru_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [63:0]        i_rad,
    output logic               o_done,
    output logic signed [31:0] o_root
);

    localparam int STEPS = 32;
    localparam int CNT_W = $clog2(STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [63:0]      r_rad;
    logic [34:0]      r_rem;
    logic [31:0]      r_root;

    logic [34:0] w_rem_sh;
    logic [34:0] w_trial;
    logic        w_ge;

    assign w_rem_sh = {r_rem[32:0], r_rad[63:62]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_ge     = w_rem_sh >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[30:0], w_ge};
        end
    end

    assign o_root = r_root[31] ? 32'sh7fffffff : $signed(r_root);
    assign o_done = r_done;

endmodule

// ===== rtl/cru_front.sv =====
// ----------------------------------------------------------------------------
// cru_front: request intake
// Accept requests, drop unused functions, queue the rest for the back end.
// ----------------------------------------------------------------------------
module cru_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic [2:0]         i_row,
    input  logic [2:0]         i_col,
    input  logic signed [31:0] i_value,
    input  logic               i_last,
    input  logic               i_downdate,
    output logic               o_req_valid,
    output cru_pkg::t_req      o_req,
    input  logic               i_req_take
);

    cru_pkg::t_req                r_q [cru_pkg::QUEUE_DEPTH];
    logic [cru_pkg::QUEUE_AW-1:0] r_wp;
    logic [cru_pkg::QUEUE_AW-1:0] r_rp;
    logic [cru_pkg::QUEUE_AW:0]   r_cnt;

    cru_pkg::t_req w_req;
    logic          w_push;
    logic          w_pop;

    always_comb begin
        w_req.func  = i_func;
        w_req.row   = i_row;
        w_req.col   = i_col;
        w_req.value = i_value;
        w_req.start = i_last && (i_func == cru_pkg::FUNC_LD);
        w_req.down  = i_downdate;
    end

    assign o_stall     = r_cnt == (cru_pkg::QUEUE_AW + 1)'(cru_pkg::QUEUE_DEPTH);
    assign w_push      = i_valid && !o_stall && (i_func != cru_pkg::FUNC_NOP);
    assign o_req_valid = r_cnt != '0;
    assign w_pop       = i_req_take && o_req_valid;
    assign o_req       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_req;
        end
    end

endmodule

// ===== rtl/cru_back.sv =====
// ----------------------------------------------------------------------------
// cru_back: request execution and update sequencer
// Carry out entry writes, reads and vector loads; run the column update.
// ----------------------------------------------------------------------------
module cru_back #(
    parameter int MAX_DIM = cru_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cru_pkg::DIM_W-1:0]     i_cfg_wdata,
    input  logic                          i_req_valid,
    input  cru_pkg::t_req                 i_req,
    output logic                          o_req_take,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_kind,
    output logic signed [31:0]            o_read_value,
    output logic [1:0]                    o_status
);

    localparam int IW    = $clog2(MAX_DIM);
    localparam int CW    = $clog2(MAX_DIM + 1);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_RD   = 5'd1;
    localparam logic [4:0] ST_COPY = 5'd2;
    localparam logic [4:0] ST_KRD  = 5'd3;
    localparam logic [4:0] ST_KA   = 5'd4;
    localparam logic [4:0] ST_MAA  = 5'd5;
    localparam logic [4:0] ST_MXX  = 5'd6;
    localparam logic [4:0] ST_CHK  = 5'd7;
    localparam logic [4:0] ST_SQW  = 5'd8;
    localparam logic [4:0] ST_DVC  = 5'd9;
    localparam logic [4:0] ST_DVCW = 5'd10;
    localparam logic [4:0] ST_DVS  = 5'd11;
    localparam logic [4:0] ST_DVSW = 5'd12;
    localparam logic [4:0] ST_WKK  = 5'd13;
    localparam logic [4:0] ST_JRD  = 5'd14;
    localparam logic [4:0] ST_JM   = 5'd15;
    localparam logic [4:0] ST_JADD = 5'd16;
    localparam logic [4:0] ST_JDW  = 5'd17;
    localparam logic [4:0] ST_JP1  = 5'd18;
    localparam logic [4:0] ST_JP2  = 5'd19;
    localparam logic [4:0] ST_JX   = 5'd20;
    localparam logic [4:0] ST_DONE = 5'd21;

    function automatic logic [CW-1:0] f_clamp(input logic [cru_pkg::DIM_W-1:0] d);
        if (d == '0) begin
            f_clamp = CW'(1);
        end else if (int'(d) > MAX_DIM) begin
            f_clamp = CW'(MAX_DIM);
        end else begin
            f_clamp = CW'(d);
        end
    endfunction

    function automatic logic [AW-1:0] f_addr(input int row, input int col);
        f_addr = AW'(row * MAX_DIM + col);
    endfunction

    logic [4:0]         r_state;
    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_k;
    logic [CW-1:0]      r_j;
    logic               r_down;
    logic               r_rzero;
    logic [1:0]         r_stat;
    logic signed [31:0] r_vec [MAX_DIM];
    logic signed [31:0] r_x   [MAX_DIM];
    logic signed [31:0] r_a;
    logic signed [31:0] r_xk;
    logic signed [31:0] r_xj;
    logic signed [31:0] r_t;
    logic signed [31:0] r_r;
    logic signed [31:0] r_c;
    logic signed [31:0] r_s;
    logic signed [31:0] r_nl;
    logic signed [40:0] r_p1;
    logic [63:0]        r_aa;
    logic [63:0]        r_prod;
    logic               r_pneg;

    logic               r_ov;
    logic               r_okind;
    logic signed [31:0] r_orv;
    logic [1:0]         r_ostat;

    // shared multiplier operands
    logic signed [31:0] w_ma;
    logic signed [31:0] w_mb;
    logic signed [40:0] w_qm;
    logic [39:0]        w_qmag;
    logic signed [41:0] w_tsum;
    logic [63:0]        w_xx;
    logic               w_out_free;
    logic               w_row_ok;
    logic               w_col_ok;

    // memory and unit control
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [31:0]        w_wdata;
    logic               w_re;
    logic [AW-1:0]      w_raddr;
    logic [31:0]        w_rdata;
    logic               w_div_start;
    logic signed [39:0] w_div_num;
    logic signed [31:0] w_div_den;
    logic               w_div_done;
    logic signed [31:0] w_div_quot;
    logic               w_sq_start;
    logic [63:0]        w_sq_rad;
    logic               w_sq_done;
    logic signed [31:0] w_sq_root;

    assign w_out_free = !r_ov || !i_stall;
    assign w_row_ok   = int'(i_req.row) < MAX_DIM;
    assign w_col_ok   = int'(i_req.col) < MAX_DIM;
    assign o_req_take = (r_state == ST_IDLE) && i_req_valid;

    assign w_qmag = r_prod[63:24];
    assign w_qm   = r_pneg ? -$signed({1'b0, w_qmag}) : $signed({1'b0, w_qmag});
    assign w_tsum = r_down ? (42'(r_t) - 42'(w_qm)) : (42'(r_t) + 42'(w_qm));
    assign w_xx   = r_prod;
    assign w_sq_rad = r_down ? (r_aa - w_xx) : (r_aa + w_xx);

    always_comb begin
        unique case (r_state)
            ST_MXX:  begin w_ma = r_xk; w_mb = r_xk; end
            ST_JM:   begin w_ma = r_s;  w_mb = r_xj; end
            ST_JP1:  begin w_ma = r_c;  w_mb = r_xj; end
            ST_JP2:  begin w_ma = r_s;  w_mb = r_nl; end
            default: begin w_ma = r_a;  w_mb = r_a;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(cru_pkg::f_mag(w_ma)) * 64'(cru_pkg::f_mag(w_mb));
        r_pneg <= w_ma[31] ^ w_mb[31];
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = f_addr(int'(i_req.row), int'(i_req.col));
        w_wdata = i_req.value;
        w_re    = 1'b0;
        w_raddr = f_addr(int'(i_req.row), int'(i_req.col));
        unique case (r_state)
            ST_IDLE: begin
                w_we = i_req_valid && (i_req.func == cru_pkg::FUNC_WR) && w_row_ok && w_col_ok;
                w_re = i_req_valid && (i_req.func == cru_pkg::FUNC_RD) && w_row_ok && w_col_ok;
            end
            ST_KRD: begin
                w_re    = r_k < r_n;
                w_raddr = f_addr(int'(r_k), int'(r_k));
            end
            ST_WKK: begin
                w_we    = 1'b1;
                w_waddr = f_addr(int'(r_k), int'(r_k));
                w_wdata = r_r;
            end
            ST_JRD: begin
                w_re    = r_j < r_n;
                w_raddr = f_addr(int'(r_j), int'(r_k));
            end
            ST_JDW: begin
                w_we    = w_div_done;
                w_waddr = f_addr(int'(r_j), int'(r_k));
                w_wdata = w_div_quot;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = 40'(r_r);
        w_div_den   = r_a;
        unique case (r_state)
            ST_DVC:  w_div_start = 1'b1;
            ST_DVS: begin
                w_div_start = 1'b1;
                w_div_num   = 40'(r_xk);
            end
            ST_JADD: begin
                w_div_start = 1'b1;
                w_div_num   = $signed(w_tsum[39:0]);
                w_div_den   = r_c;
            end
            default: begin
            end
        endcase
    end

    assign w_sq_start = (r_state == ST_CHK) && !(r_down && (w_xx > r_aa)) && (r_a != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n     <= f_clamp(cru_pkg::DIM_RESET);
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_n <= f_clamp(i_cfg_wdata);
            end
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req_valid) begin
                        case (i_req.func)
                            cru_pkg::FUNC_RD: r_state <= ST_RD;
                            cru_pkg::FUNC_LD: begin
                                if (i_req.start) begin
                                    r_state <= ST_COPY;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_RD: begin
                    if (w_out_free) begin
                        r_ov    <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                ST_COPY: r_state <= ST_KRD;
                ST_KRD:  r_state <= (r_k < r_n) ? ST_KA : ST_DONE;
                ST_KA:   r_state <= ST_MAA;
                ST_MAA:  r_state <= ST_MXX;
                ST_MXX:  r_state <= ST_CHK;
                ST_CHK:  r_state <= w_sq_start ? ST_SQW : ST_DONE;
                ST_SQW: begin
                    if (w_sq_done) begin
                        r_state <= ST_DVC;
                    end
                end
                ST_DVC: r_state <= ST_DVCW;
                ST_DVCW: begin
                    if (w_div_done) begin
                        r_state <= ST_DVS;
                    end
                end
                ST_DVS: r_state <= ST_DVSW;
                ST_DVSW: begin
                    if (w_div_done) begin
                        r_state <= (r_c == '0) ? ST_DONE : ST_WKK;
                    end
                end
                ST_WKK: r_state <= ST_JRD;
                ST_JRD: r_state <= (r_j < r_n) ? ST_JM : ST_KRD;
                ST_JM:   r_state <= ST_JADD;
                ST_JADD: r_state <= ST_JDW;
                ST_JDW: begin
                    if (w_div_done) begin
                        r_state <= ST_JP1;
                    end
                end
                ST_JP1: r_state <= ST_JP2;
                ST_JP2: r_state <= ST_JX;
                ST_JX:  r_state <= ST_JRD;
                ST_DONE: begin
                    if (w_out_free) begin
                        r_ov    <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_rzero <= !(w_row_ok && w_col_ok);
                r_down  <= i_req.down;
                if (i_req_valid && (i_req.func == cru_pkg::FUNC_LD) && w_row_ok) begin
                    r_vec[IW'(i_req.row)] <= i_req.value;
                end
            end
            ST_RD: begin
                if (w_out_free) begin
                    r_okind <= cru_pkg::KIND_READ;
                    r_orv   <= r_rzero ? 32'sd0 : $signed(w_rdata);
                    r_ostat <= cru_pkg::STAT_OK;
                end
            end
            ST_COPY: begin
                r_x    <= r_vec;
                r_k    <= '0;
                r_stat <= cru_pkg::STAT_OK;
            end
            ST_KRD: begin
                r_xk <= r_x[r_k[IW-1:0]];
            end
            ST_KA:  r_a  <= $signed(w_rdata);
            ST_MXX: r_aa <= r_prod;
            ST_CHK: begin
                if (r_down && (w_xx > r_aa)) begin
                    r_stat <= cru_pkg::STAT_NEGRAD;
                end else if (r_a == '0) begin
                    r_stat <= cru_pkg::STAT_ZPIV;
                end
            end
            ST_SQW: begin
                if (w_sq_done) begin
                    r_r <= w_sq_root;
                end
            end
            ST_DVCW: begin
                if (w_div_done) begin
                    r_c <= w_div_quot;
                end
            end
            ST_DVSW: begin
                if (w_div_done) begin
                    r_s <= w_div_quot;
                    if (r_c == '0) begin
                        r_stat <= cru_pkg::STAT_ZPIV;
                    end
                end
            end
            ST_WKK: r_j <= r_k + 1'b1;
            ST_JRD: begin
                if (r_j < r_n) begin
                    r_xj <= r_x[r_j[IW-1:0]];
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            ST_JM: r_t <= $signed(w_rdata);
            ST_JDW: begin
                if (w_div_done) begin
                    r_nl <= w_div_quot;
                end
            end
            ST_JP2: r_p1 <= w_qm;
            ST_JX: begin
                r_x[r_j[IW-1:0]] <= cru_pkg::f_sat32(48'(r_p1) - 48'(w_qm));
                r_j <= r_j + 1'b1;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    r_okind <= cru_pkg::KIND_DONE;
                    r_orv   <= 32'sd0;
                    r_ostat <= r_stat;
                end
            end
            default: begin
            end
        endcase
    end

    cru_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_factor (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    cru_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_div_num),
        .i_den  (w_div_den),
        .o_done (w_div_done),
        .o_quot (w_div_quot)
    );

    cru_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_sq_start),
        .i_rad  (w_sq_rad),
        .o_done (w_sq_done),
        .o_root (w_sq_root)
    );

    assign o_valid      = r_ov;
    assign o_kind       = r_okind;
    assign o_read_value = r_orv;
    assign o_status     = r_ostat;

endmodule

// ===== rtl/cholesky_rank_one_update.sv =====
// ----------------------------------------------------------------------------
// cholesky_rank_one_update: fixed-point Cholesky factor update and downdate
// Holds a lower-triangular Q8.24 factor, takes entry writes, reads and vector
// loads, and runs a rank-one update or downdate when the last element lands.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  --------  ---------  ----------------------  ----------------------------------
//  request   in         i_valid / o_stall       i_func i_row i_col i_value
//                                               i_last i_downdate
//  result    out        o_valid / i_stall       o_kind o_read_value o_status
//  config    in         i_cfg_we                i_cfg_wdata (dimension)
//
//  Update: the 64-step divider runs twice per column and once per
//  below-diagonal entry; the 32-step square root runs once per column.
//  Reset: synchronous, active low; the factor and vector stores are not cleared.
//  Stalls: a two-entry request queue lets intake continue while the back end
//  works; the result register holds a result until the consumer takes it.
//
module cholesky_rank_one_update #(
    parameter int MAX_DIM = cru_pkg::MAX_DIM_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cru_pkg::DIM_W-1:0] i_cfg_wdata,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_func,
    input  logic [2:0]                i_row,
    input  logic [2:0]                i_col,
    input  logic signed [31:0]        i_value,
    input  logic                      i_last,
    input  logic                      i_downdate,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_kind,
    output logic signed [31:0]        o_read_value,
    output logic [1:0]                o_status
);

    // queue handoff between intake and execution
    logic          w_req_valid;
    logic          w_req_take;
    cru_pkg::t_req w_req;

    // intake: accept, drop unused function codes, queue
    cru_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_func     (i_func),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_value    (i_value),
        .i_last     (i_last),
        .i_downdate (i_downdate),
        .o_req_valid(w_req_valid),
        .o_req      (w_req),
        .i_req_take (w_req_take)
    );

    // execution: factor memory, sequencer, divider, square root
    cru_back #(
        .MAX_DIM(MAX_DIM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .o_req_take  (w_req_take),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_read_value(o_read_value),
        .o_status    (o_status)
    );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Cholesky rank-one update testbench
// Drives entry writes, reads and vector loads through the request channel,
// predicts every read and update result with a local Q8.24 model of the
// factor, and checks each result against the oldest prediction. Sender bursts,
// receiver stalls, a long receiver hold-off and dimension changes are covered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int N_DIM       = 8;
    localparam int WATCH_LIMIT = 40000;   // idle cycles before giving up
    localparam int Q_ONE       = 32'h0100_0000;

    typedef struct {
        logic [1:0]         func;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
        logic               last;
        logic               down;
    } t_item;

    typedef struct {
        logic               kind;
        logic signed [31:0] read_value;
        logic [1:0]         status;
    } t_result;

    // DUT ports
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [cru_pkg::DIM_W-1:0]   i_cfg_wdata = '0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic [1:0]                  i_func = cru_pkg::FUNC_NOP;
    logic [2:0]                  i_row = '0;
    logic [2:0]                  i_col = '0;
    logic signed [31:0]          i_value = '0;
    logic                        i_last = 1'b0;
    logic                        i_downdate = 1'b0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic                        o_kind;
    logic signed [31:0]          o_read_value;
    logic [1:0]                  o_status;

    // Local copy of the factor, the vector buffer and the dimension register
    int                          factor_mem [N_DIM][N_DIM];
    int                          vec_mem [N_DIM];
    logic [cru_pkg::DIM_W-1:0]   dim_reg = cru_pkg::DIM_RESET;

    t_item               request_queue[$];
    t_result             expected_results[$];
    t_item               req_cur;
    bit                  req_taken = 0;
    bit                  failed = 0;
    int                  gap_left = 0;
    int                  burst_left = 0;
    int                  holdoff_asked = 0;
    int                  holdoff_served = 0;
    int                  holdoff_left = 0;
    int                  stall_pct = 0;
    int                  stall_phase = 0;
    int                  idle_cycles = 0;

    cholesky_rank_one_update dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_value      (i_value),
        .i_last       (i_last),
        .i_downdate   (i_downdate),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_read_value (o_read_value),
        .o_status     (o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Q8.24 arithmetic of the factor update
    // ------------------------------------------------------------------
    function automatic longint unsigned abs64(input longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic int sat32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fff_ffff;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return int'(v);
    endfunction

    // product truncated toward zero
    function automatic longint q_mul(input longint a, input longint b);
        longint unsigned p;
        p = (abs64(a) * abs64(b)) >> 24;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    // quotient truncated toward zero
    function automatic longint q_div(input longint num, input longint den);
        longint unsigned q;
        q = (abs64(num) << 24) / abs64(den);
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Rotate the factor column by column; return the finishing status.
    function automatic logic [1:0] rank_one_rotate(input bit down);
        int              x [N_DIM];
        int              n;
        longint          a, xk, r, c, s, t, m;
        longint unsigned aa, xx, rad, r64;
        int              nl;
        n = dim_reg;
        if (n == 0) n = 1;
        if (n > N_DIM) n = N_DIM;
        x = vec_mem;
        for (int k = 0; k < n; k++) begin
            a  = factor_mem[k][k];
            xk = x[k];
            aa = abs64(a) * abs64(a);
            xx = abs64(xk) * abs64(xk);
            if (down) begin
                if (xx > aa) return cru_pkg::STAT_NEGRAD;
                rad = aa - xx;
            end else begin
                rad = aa + xx;
            end
            if (a == 0) return cru_pkg::STAT_ZPIV;
            r64 = floor_sqrt(rad);
            r = (r64 > 64'd2147483647) ? 64'sd2147483647 : longint'(r64);
            c = sat32(q_div(r, a));
            s = sat32(q_div(xk, a));
            if (c == 0) return cru_pkg::STAT_ZPIV;
            factor_mem[k][k] = int'(r);
            for (int j = k + 1; j < n; j++) begin
                t  = factor_mem[j][k];
                m  = q_mul(s, x[j]);
                t  = down ? t - m : t + m;
                nl = sat32(q_div(t, c));
                factor_mem[j][k] = nl;
                x[j] = sat32(q_mul(c, x[j]) - q_mul(s, nl));
            end
        end
        return cru_pkg::STAT_OK;
    endfunction

    // Apply one accepted request; queue the result it causes, if any.
    function automatic void apply_request(input t_item it);
        t_result res;
        case (it.func)
            cru_pkg::FUNC_WR: factor_mem[it.row][it.col] = it.value;
            cru_pkg::FUNC_RD: begin
                res.kind       = cru_pkg::KIND_READ;
                res.read_value = factor_mem[it.row][it.col];
                res.status     = cru_pkg::STAT_OK;
                expected_results.push_back(res);
            end
            cru_pkg::FUNC_LD: begin
                vec_mem[it.row] = it.value;
                if (it.last) begin
                    res.kind       = cru_pkg::KIND_DONE;
                    res.read_value = '0;
                    res.status     = rank_one_rotate(it.down);
                    expected_results.push_back(res);
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_req(input logic [1:0] f, input int r, input int c,
                                    input logic [31:0] v, input bit l, input bit d);
        t_item it;
        it.func = f;
        it.row = r[2:0];
        it.col = c[2:0];
        it.value = v;
        it.last = l;
        it.down = d;
        request_queue.push_back(it);
    endfunction

    function automatic logic [31:0] small_q(input int span);
        return 32'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic int eff_dim();
        if (dim_reg == 0) return 1;
        if (dim_reg > N_DIM) return N_DIM;
        return dim_reg;
    endfunction

    // Well-conditioned factor and a modest vector, then start the update and follow it with one to four reads.
    function automatic void add_update_seq(input int n, input bit d);
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c <= r; c++) begin
                if (r == c)
                    add_req(cru_pkg::FUNC_WR, r, c, Q_ONE + $urandom_range(0, Q_ONE), 0, 0);
                else
                    add_req(cru_pkg::FUNC_WR, r, c, small_q(Q_ONE / 4), 0, 0);
            end
        end
        for (int r = 0; r < n; r++)
            add_req(cru_pkg::FUNC_LD, r, $urandom_range(0, 7),
                    small_q(d ? Q_ONE / 2 : Q_ONE), r == n - 1, d);
        for (int i = 0; i < $urandom_range(1, 4); i++)
            add_req(cru_pkg::FUNC_RD, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                    $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
    endfunction

    // Arbitrary requests: any func, any index, full-range values.
    function automatic void add_noise(input int cnt);
        for (int i = 0; i < cnt; i++)
            add_req($urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 7),
                    $urandom, $urandom_range(0, 19) == 0, $urandom_range(0, 1));
    endfunction

    task automatic wait_idle();
        while (request_queue.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        // let trailing writes and loads settle in the back end
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_dimension(input logic [cru_pkg::DIM_W-1:0] d);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= d;
        dim_reg = d;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Driver: record acceptance at the rising edge, advance at the falling
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            apply_request(req_cur);
            req_taken = 1;
        end
    end

    always @(negedge i_clk) begin
        t_item it;
        logic  nv;
        if (i_rst_n && (req_taken || !i_valid)) begin
            req_taken = 0;
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (request_queue.size() != 0) begin
                it = request_queue.pop_front();
                req_cur    = it;
                i_func     <= it.func;
                i_row      <= it.row;
                i_col      <= it.col;
                i_value    <= it.value;
                i_last     <= it.last;
                i_downdate <= it.down;
                nv = 1'b1;
                // close the burst and draw a gap, often none at all
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
            i_valid <= nv;
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern: random density that changes over time,
    // plus a long hold-off on request from the stimulus process
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (holdoff_asked != holdoff_served) begin
            holdoff_served = holdoff_asked;
            holdoff_left = 600;
        end
        if (stall_phase == 0) begin
            stall_phase = $urandom_range(50, 300);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
        end else begin
            stall_phase--;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0d value %0d status %0d",
                       o_kind, o_read_value, o_status);
                failed = 1;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_kind !== exp_res.kind) begin
                    $error("kind: expected %0d, got %0d", exp_res.kind, o_kind);
                    failed = 1;
                end
                if (o_read_value !== exp_res.read_value) begin
                    $error("read_value: expected %0d, got %0d",
                           exp_res.read_value, o_read_value);
                    failed = 1;
                end
                if (o_status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, o_status);
                    failed = 1;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves while work is pending
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n
                || (expected_results.size() == 0 && !i_valid)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCH_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        logic [cru_pkg::DIM_W-1:0] dims [7];
        int                        budget;
        dims = '{4'd1, 4'd2, 4'd4, 4'd8, 4'd5, 4'd0, 4'd15};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Fill every store entry so nothing is ever read uninitialized
        for (int r = 0; r < N_DIM; r++)
            for (int c = 0; c < N_DIM; c++)
                add_req(cru_pkg::FUNC_WR, r, c,
                        (r == c) ? Q_ONE : small_q(Q_ONE / 8), 0, 0);
        for (int r = 0; r < N_DIM; r++)
            add_req(cru_pkg::FUNC_LD, r, 0, small_q(Q_ONE / 8), 0, 0);
        set_dimension(4'd8);

        // Directed: extremes, upper triangle, ignored func, error exits
        add_req(cru_pkg::FUNC_WR, 7, 7, 32'h7fff_ffff, 0, 0);
        add_req(cru_pkg::FUNC_RD, 7, 7, 0, 0, 0);
        add_req(cru_pkg::FUNC_WR, 0, 7, 32'h8000_0000, 1, 1);
        add_req(cru_pkg::FUNC_RD, 0, 7, 32'hffff_ffff, 1, 1);
        add_req(cru_pkg::FUNC_NOP, 3, 3, 32'h1234_5678, 1, 1);
        add_req(cru_pkg::FUNC_RD, 3, 3, 0, 0, 0);
        add_req(cru_pkg::FUNC_WR, 7, 7, Q_ONE, 0, 0);
        // zero pivot in the first column
        add_req(cru_pkg::FUNC_WR, 0, 0, 0, 0, 0);
        add_req(cru_pkg::FUNC_LD, 0, 0, Q_ONE, 1, 0);
        // downdate with a radicand below zero
        add_req(cru_pkg::FUNC_WR, 0, 0, Q_ONE, 0, 0);
        add_req(cru_pkg::FUNC_LD, 0, 0, 2 * Q_ONE, 1, 1);
        // extreme vector element through an update
        add_req(cru_pkg::FUNC_LD, 0, 0, 32'h7fff_ffff, 0, 0);
        add_req(cru_pkg::FUNC_LD, 7, 0, 32'h8000_0000, 1, 0);
        add_req(cru_pkg::FUNC_RD, 1, 0, 0, 0, 0);
        add_update_seq(3, 0);
        add_update_seq(3, 1);

        // Random phases over a range of dimensions
        foreach (dims[p]) begin
            set_dimension(dims[p]);
            if (p == 2) begin
                // long receiver hold-off while requests keep coming
                holdoff_asked++;
                for (int i = 0; i < 16; i++)
                    add_req(cru_pkg::FUNC_RD, $urandom_range(0, 7), $urandom_range(0, 7),
                            0, 0, 0);
            end
            budget = request_queue.size() + 250;
            while (request_queue.size() < budget) begin
                if ($urandom_range(0, 99) < 55)
                    add_update_seq(eff_dim(), $urandom_range(0, 1));
                else
                    add_noise($urandom_range(1, 10));
            end
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (!failed && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
